@@ hdl/sfd_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfd_pkg: shared types and constants of the byte-stuffing frame decoder
// Word formats, configuration record, register indexes, phase and status codes.
// ----------------------------------------------------------------------------
package sfd_pkg;

  localparam int BYTE_BITS    = 8;
  localparam int CRC_BITS     = 16;
  localparam int CFG_IDX_BITS = 8;
  localparam int CFG_DAT_BITS = 16;

  // Register indexes on the configuration port
  localparam logic [CFG_IDX_BITS-1:0] CFG_FRAME_BYTE   = 8'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_ESCAPE_BYTE  = 8'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_FRAME_SUBST  = 8'd2;
  localparam logic [CFG_IDX_BITS-1:0] CFG_ESCAPE_SUBST = 8'd3;
  localparam logic [CFG_IDX_BITS-1:0] CFG_CRC_POLY     = 8'd4;
  localparam logic [CFG_IDX_BITS-1:0] CFG_CRC_SEED     = 8'd5;
  localparam logic [CFG_IDX_BITS-1:0] CFG_CRC_XOROUT   = 8'd6;
  localparam logic [CFG_IDX_BITS-1:0] CFG_CRC_REFLECT  = 8'd7;

  // Register values after reset
  localparam logic [BYTE_BITS-1:0] RST_FRAME_BYTE   = 8'd126;
  localparam logic [BYTE_BITS-1:0] RST_ESCAPE_BYTE  = 8'd125;
  localparam logic [BYTE_BITS-1:0] RST_FRAME_SUBST  = 8'd94;
  localparam logic [BYTE_BITS-1:0] RST_ESCAPE_SUBST = 8'd93;
  localparam logic [CRC_BITS-1:0]  RST_CRC_POLY     = 16'h8005;
  localparam logic [CRC_BITS-1:0]  RST_CRC_SEED     = 16'h0000;
  localparam logic [CRC_BITS-1:0]  RST_CRC_XOROUT   = 16'h0000;
  localparam logic                 RST_CRC_REFLECT  = 1'b1;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_BODY = 2'd1,
    PH_DROP = 2'd2
  } phase_t;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_CRC     = 3'd1,
    ST_ESC     = 3'd2,
    ST_SHORT   = 3'd3,
    ST_FRAMING = 3'd4
  } status_t;

  typedef struct packed {
    logic [BYTE_BITS-1:0] frame_byte;
    logic [BYTE_BITS-1:0] escape_byte;
    logic [BYTE_BITS-1:0] frame_subst;
    logic [BYTE_BITS-1:0] escape_subst;
    logic [CRC_BITS-1:0]  crc_poly;
    logic [CRC_BITS-1:0]  crc_seed;
    logic [CRC_BITS-1:0]  crc_xorout;
    logic                 crc_reflect;
  } cfg_t;

  typedef struct packed {
    logic [BYTE_BITS-1:0] in_byte;
    logic                 in_last;
  } in_word_t;

  typedef struct packed {
    logic                 out_has_byte;
    logic [BYTE_BITS-1:0] out_byte;
    logic                 out_last;
    status_t              status;
  } out_word_t;

endpackage

@@ hdl/sfd_crc.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfd_crc: byte-wide CRC-16 update and final remainder
// Folds one byte into the remainder in a single unrolled step and forms the
// finished check value (optional reflection, then xorout).
// ----------------------------------------------------------------------------
module sfd_crc (
  input  sfd_pkg::cfg_t                      cfg,
  input  logic [sfd_pkg::CRC_BITS-1:0]       crc_cur,
  input  logic [sfd_pkg::BYTE_BITS-1:0]      data,
  output logic [sfd_pkg::CRC_BITS-1:0]       crc_upd,
  output logic [sfd_pkg::CRC_BITS-1:0]       crc_fin
);

  logic [sfd_pkg::BYTE_BITS-1:0] data_m;
  logic [sfd_pkg::CRC_BITS-1:0]  crc_m;

  // Mirror the data byte and the remainder
  always_comb begin
    for (int i = 0; i < sfd_pkg::BYTE_BITS; i++) begin
      data_m[i] = data[sfd_pkg::BYTE_BITS-1-i];
    end
    for (int i = 0; i < sfd_pkg::CRC_BITS; i++) begin
      crc_m[i] = crc_cur[sfd_pkg::CRC_BITS-1-i];
    end
  end

  // Shift eight bits through the generator, MSB first
  always_comb begin
    logic [sfd_pkg::CRC_BITS-1:0] rem;
    rem = crc_cur ^ {(cfg.crc_reflect ? data_m : data), {sfd_pkg::BYTE_BITS{1'b0}}};
    for (int i = 0; i < sfd_pkg::BYTE_BITS; i++) begin
      if (rem[sfd_pkg::CRC_BITS-1]) begin
        rem = {rem[sfd_pkg::CRC_BITS-2:0], 1'b0} ^ cfg.crc_poly;
      end else begin
        rem = {rem[sfd_pkg::CRC_BITS-2:0], 1'b0};
      end
    end
    crc_upd = rem;
  end

  // Finished check value
  assign crc_fin = (cfg.crc_reflect ? crc_m : crc_cur) ^ cfg.crc_xorout;

endmodule

@@ hdl/sfd_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfd_core: frame state and per-byte decode
// Holds the frame phase, escape flag, two-byte hold and CRC remainder, and
// computes the result word for the byte at its input in one pass.
// ----------------------------------------------------------------------------
module sfd_core (
  input  logic                clk,
  input  logic                rst,
  input  sfd_pkg::cfg_t       cfg,
  input  sfd_pkg::in_word_t   word,
  input  logic                fire,
  output logic                res_valid,
  output sfd_pkg::out_word_t  res
);

  sfd_pkg::phase_t                   phase, phase_next;
  logic                              escape_pending, escape_pending_next;
  logic [2*sfd_pkg::BYTE_BITS-1:0]   hold_bytes, hold_bytes_next;
  logic [1:0]                        hold_count, hold_count_next;
  logic [sfd_pkg::CRC_BITS-1:0]      crc_remainder, crc_remainder_next;

  logic [sfd_pkg::CRC_BITS-1:0]      crc_upd;
  logic [sfd_pkg::CRC_BITS-1:0]      crc_fin;
  logic [sfd_pkg::BYTE_BITS-1:0]     old_byte;

  assign old_byte = hold_bytes[2*sfd_pkg::BYTE_BITS-1:sfd_pkg::BYTE_BITS];

  sfd_crc u_crc (
    .cfg     (cfg),
    .crc_cur (crc_remainder),
    .data    (old_byte),
    .crc_upd (crc_upd),
    .crc_fin (crc_fin)
  );

  // Hold the frame state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= sfd_pkg::PH_IDLE;
      escape_pending <= 1'b0;
      hold_bytes     <= '0;
      hold_count     <= '0;
      crc_remainder  <= '0;
    end else if (fire) begin
      phase          <= phase_next;
      escape_pending <= escape_pending_next;
      hold_bytes     <= hold_bytes_next;
      hold_count     <= hold_count_next;
      crc_remainder  <= crc_remainder_next;
    end
  end

  // Decode one byte and form its result word
  always_comb begin
    logic                          have_d;
    logic [sfd_pkg::BYTE_BITS-1:0] d;
    have_d              = 1'b0;
    d                   = word.in_byte;
    phase_next          = phase;
    escape_pending_next = escape_pending;
    hold_bytes_next     = hold_bytes;
    hold_count_next     = hold_count;
    crc_remainder_next  = crc_remainder;
    res_valid           = 1'b0;
    res                 = '0;
    res.status          = sfd_pkg::ST_OK;

    unique case (phase)
      sfd_pkg::PH_DROP: begin
        // Discard until the marked last byte
        if (word.in_last) begin
          phase_next = sfd_pkg::PH_IDLE;
        end
      end

      sfd_pkg::PH_BODY: begin
        if (word.in_last) begin
          // End of frame: report status only
          phase_next   = sfd_pkg::PH_IDLE;
          res_valid    = 1'b1;
          res.out_last = 1'b1;
          if (word.in_byte != cfg.frame_byte) begin
            res.status = sfd_pkg::ST_FRAMING;
          end else if (escape_pending) begin
            res.status = sfd_pkg::ST_ESC;
          end else if (hold_count < 2'd2) begin
            res.status = sfd_pkg::ST_SHORT;
          end else if (crc_fin == hold_bytes) begin
            res.status = sfd_pkg::ST_OK;
          end else begin
            res.status = sfd_pkg::ST_CRC;
          end
        end else if (escape_pending) begin
          // Resolve the escape pair
          escape_pending_next = 1'b0;
          if (word.in_byte == cfg.escape_subst) begin
            d      = cfg.escape_byte;
            have_d = 1'b1;
          end else if (word.in_byte == cfg.frame_subst) begin
            d      = cfg.frame_byte;
            have_d = 1'b1;
          end else begin
            phase_next   = sfd_pkg::PH_DROP;
            res_valid    = 1'b1;
            res.out_last = 1'b1;
            res.status   = sfd_pkg::ST_ESC;
          end
        end else if (word.in_byte == cfg.escape_byte) begin
          escape_pending_next = 1'b1;
        end else begin
          have_d = 1'b1;
        end

        // Push the decoded byte through the two-byte hold
        if (have_d) begin
          hold_bytes_next = {hold_bytes[sfd_pkg::BYTE_BITS-1:0], d};
          if (hold_count < 2'd2) begin
            hold_count_next = 2'(hold_count + 2'd1);
          end else begin
            crc_remainder_next = crc_upd;
            res_valid          = 1'b1;
            res.out_has_byte   = 1'b1;
            res.out_byte       = old_byte;
          end
        end
      end

      default: begin
        // Awaiting frame start
        escape_pending_next = 1'b0;
        hold_bytes_next     = '0;
        hold_count_next     = '0;
        crc_remainder_next  = cfg.crc_seed;
        if (word.in_byte != cfg.frame_byte) begin
          phase_next   = word.in_last ? sfd_pkg::PH_IDLE : sfd_pkg::PH_DROP;
          res_valid    = 1'b1;
          res.out_last = 1'b1;
          res.status   = sfd_pkg::ST_FRAMING;
        end else if (word.in_last) begin
          phase_next   = sfd_pkg::PH_IDLE;
          res_valid    = 1'b1;
          res.out_last = 1'b1;
          res.status   = sfd_pkg::ST_SHORT;
        end else begin
          phase_next = sfd_pkg::PH_BODY;
        end
      end
    endcase
  end

endmodule

@@ hdl/byte_stuffing_frame_decoder_crc16.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// byte_stuffing_frame_decoder_crc16: deframer with escape decode and CRC-16
// A byte is held in the input register, then its result word in the result register.
// Throughput: one byte per cycle; the byte in the input register advances
// whenever it makes no word or the result register is free or being taken.
// Reset clears the handshake, the frame state and returns every configuration
// register to its default; no clearing pass is needed.
// ----------------------------------------------------------------------------
module byte_stuffing_frame_decoder_crc16 (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                item_valid,
  output logic                                item_stall,
  input  sfd_pkg::in_word_t                   item,
  output logic                                result_valid,
  input  logic                                result_stall,
  output sfd_pkg::out_word_t                  result,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [sfd_pkg::CFG_IDX_BITS-1:0]    cfg_index,
  input  logic [sfd_pkg::CFG_DAT_BITS-1:0]    cfg_data
);

  sfd_pkg::cfg_t      cfg;
  sfd_pkg::in_word_t  inq;
  logic               inq_valid;
  logic               core_res_valid;
  sfd_pkg::out_word_t core_res;
  logic               advance;
  logic               item_take;

  assign cfg_ready = 1'b1;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.frame_byte   <= sfd_pkg::RST_FRAME_BYTE;
      cfg.escape_byte  <= sfd_pkg::RST_ESCAPE_BYTE;
      cfg.frame_subst  <= sfd_pkg::RST_FRAME_SUBST;
      cfg.escape_subst <= sfd_pkg::RST_ESCAPE_SUBST;
      cfg.crc_poly     <= sfd_pkg::RST_CRC_POLY;
      cfg.crc_seed     <= sfd_pkg::RST_CRC_SEED;
      cfg.crc_xorout   <= sfd_pkg::RST_CRC_XOROUT;
      cfg.crc_reflect  <= sfd_pkg::RST_CRC_REFLECT;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        sfd_pkg::CFG_FRAME_BYTE:   cfg.frame_byte   <= cfg_data[sfd_pkg::BYTE_BITS-1:0];
        sfd_pkg::CFG_ESCAPE_BYTE:  cfg.escape_byte  <= cfg_data[sfd_pkg::BYTE_BITS-1:0];
        sfd_pkg::CFG_FRAME_SUBST:  cfg.frame_subst  <= cfg_data[sfd_pkg::BYTE_BITS-1:0];
        sfd_pkg::CFG_ESCAPE_SUBST: cfg.escape_subst <= cfg_data[sfd_pkg::BYTE_BITS-1:0];
        sfd_pkg::CFG_CRC_POLY:     cfg.crc_poly     <= cfg_data[sfd_pkg::CRC_BITS-1:0];
        sfd_pkg::CFG_CRC_SEED:     cfg.crc_seed     <= cfg_data[sfd_pkg::CRC_BITS-1:0];
        sfd_pkg::CFG_CRC_XOROUT:   cfg.crc_xorout   <= cfg_data[sfd_pkg::CRC_BITS-1:0];
        sfd_pkg::CFG_CRC_REFLECT:  cfg.crc_reflect  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Advance the held byte when its word has somewhere to go
  assign advance    = inq_valid && (!core_res_valid || !result_valid || !result_stall);
  assign item_stall = inq_valid && !advance;
  assign item_take  = item_valid && !item_stall;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      inq_valid <= 1'b0;
    end else if (item_take) begin
      inq_valid <= 1'b1;
    end else if (advance) begin
      inq_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (item_take) begin
      inq <= item;
    end
  end

  sfd_core u_core (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .word      (inq),
    .fire      (advance),
    .res_valid (core_res_valid),
    .res       (core_res)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance && core_res_valid) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && core_res_valid) begin
      result <= core_res;
    end
  end

  // A stalled result word is never dropped
  a_hold_result: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result_stall) |=> result_valid)
    else $error("result word lost under stall");

  // A payload word never closes a frame
  a_byte_not_last: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> !(result.out_has_byte && result.out_last))
    else $error("payload word marked last");

  // Only the closing word carries a status other than ok
  a_status_on_last: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !result.out_last) |-> (result.status == sfd_pkg::ST_OK))
    else $error("status on a payload word");

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for the byte-stuffing frame decoder with CRC-16
// Sends well-formed, corrupted and noise packets through the stall handshake
// under several register settings. An in-bench decoder predicts every result
// word, and each accepted word is checked in order against that prediction.
// ----------------------------------------------------------------------------
module tb;

  localparam int NUM_REGS      = 8;
  localparam int IDLE_PCT      = 7;
  localparam int SETTLE_CYCLES = 8;
  localparam int RANDOM_ITEMS  = 700;
  localparam int PHASE_ITEMS   = 250;
  localparam int QUIET_ITEMS   = 300;

  typedef enum int {
    FR_GOOD,
    FR_BAD_CRC,
    FR_BAD_ESC,
    FR_ESC_END,
    FR_SHORT,
    FR_BAD_START,
    FR_BAD_END
  } frame_kind_t;

  logic                             clk          = 1'b0;
  logic                             rst          = 1'b1;
  logic                             item_valid   = 1'b0;
  logic                             item_stall;
  sfd_pkg::in_word_t                item         = '0;
  logic                             result_valid;
  logic                             result_stall = 1'b0;
  sfd_pkg::out_word_t               result;
  logic                             cfg_valid    = 1'b0;
  logic                             cfg_ready;
  logic [sfd_pkg::CFG_IDX_BITS-1:0] cfg_index    = '0;
  logic [sfd_pkg::CFG_DAT_BITS-1:0] cfg_data     = '0;

  bit quiet      = 1'b0;
  int errors     = 0;
  int items_sent = 0;

  // Predicted decoder state and its copy of the registers
  sfd_pkg::cfg_t   dec_cfg;
  sfd_pkg::phase_t dec_phase;
  logic            dec_esc;
  logic [15:0]     dec_hold;
  logic [1:0]      dec_hold_cnt;
  logic [15:0]     dec_crc;

  sfd_pkg::out_word_t expected_words[$];

  byte_stuffing_frame_decoder_crc16 u_top (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Advance the CRC remainder by one byte
  function automatic logic [15:0] crc_feed(input logic [15:0] rem, input logic [7:0] b);
    logic [7:0]  d;
    logic [15:0] r;
    int          i;
    d = b;
    if (dec_cfg.crc_reflect) begin
      for (i = 0; i < 8; i++) d[i] = b[7-i];
    end
    r = rem ^ {d, 8'h00};
    for (i = 0; i < 8; i++) begin
      if (r[15]) r = (r << 1) ^ dec_cfg.crc_poly;
      else r = r << 1;
    end
    return r;
  endfunction

  // Turn a remainder into the value carried in the frame
  function automatic logic [15:0] crc_final_value(input logic [15:0] rem);
    logic [15:0] r;
    int          i;
    r = rem;
    if (dec_cfg.crc_reflect) begin
      for (i = 0; i < 16; i++) r[i] = rem[15-i];
    end
    return r ^ dec_cfg.crc_xorout;
  endfunction

  // Decode one accepted byte; return 1 when it makes a result word
  function automatic bit decode_byte(input sfd_pkg::in_word_t w,
                                     output sfd_pkg::out_word_t o);
    logic [7:0] d;
    logic [7:0] old;
    o = '0;
    o.status = sfd_pkg::ST_OK;
    if (dec_phase == sfd_pkg::PH_DROP) begin
      if (w.in_last) dec_phase = sfd_pkg::PH_IDLE;
      return 1'b0;
    end
    // Frame start: clear the body state and check the opening byte
    if (dec_phase != sfd_pkg::PH_BODY) begin
      dec_esc      = 1'b0;
      dec_hold     = '0;
      dec_hold_cnt = '0;
      dec_crc      = dec_cfg.crc_seed;
      o.out_last   = 1'b1;
      if (w.in_byte != dec_cfg.frame_byte) begin
        if (w.in_last) dec_phase = sfd_pkg::PH_IDLE;
        else dec_phase = sfd_pkg::PH_DROP;
        o.status = sfd_pkg::ST_FRAMING;
        return 1'b1;
      end
      if (w.in_last) begin
        dec_phase = sfd_pkg::PH_IDLE;
        o.status  = sfd_pkg::ST_SHORT;
        return 1'b1;
      end
      dec_phase = sfd_pkg::PH_BODY;
      return 1'b0;
    end
    // Frame end: closing byte first, then pending escape, length and CRC
    if (w.in_last) begin
      dec_phase  = sfd_pkg::PH_IDLE;
      o.out_last = 1'b1;
      if (w.in_byte != dec_cfg.frame_byte) o.status = sfd_pkg::ST_FRAMING;
      else if (dec_esc) o.status = sfd_pkg::ST_ESC;
      else if (dec_hold_cnt < 2'd2) o.status = sfd_pkg::ST_SHORT;
      else if (crc_final_value(dec_crc) == dec_hold) o.status = sfd_pkg::ST_OK;
      else o.status = sfd_pkg::ST_CRC;
      return 1'b1;
    end
    // Undo the stuffing
    if (dec_esc) begin
      dec_esc = 1'b0;
      if (w.in_byte == dec_cfg.escape_subst) d = dec_cfg.escape_byte;
      else if (w.in_byte == dec_cfg.frame_subst) d = dec_cfg.frame_byte;
      else begin
        dec_phase  = sfd_pkg::PH_DROP;
        o.out_last = 1'b1;
        o.status   = sfd_pkg::ST_ESC;
        return 1'b1;
      end
    end else if (w.in_byte == dec_cfg.escape_byte) begin
      dec_esc = 1'b1;
      return 1'b0;
    end else begin
      d = w.in_byte;
    end
    // Hold two bytes back; push the oldest out once the hold is full
    if (dec_hold_cnt < 2'd2) begin
      dec_hold     = {dec_hold[7:0], d};
      dec_hold_cnt = dec_hold_cnt + 2'd1;
      return 1'b0;
    end
    old            = dec_hold[15:8];
    dec_crc        = crc_feed(dec_crc, old);
    dec_hold       = {dec_hold[7:0], d};
    o.out_has_byte = 1'b1;
    o.out_byte     = old;
    return 1'b1;
  endfunction

  task automatic report_mismatch(input string what, input logic [15:0] got,
                                 input logic [15:0] want);
    $display("ERROR %0t ns: %s got 0x%0h expected 0x%0h", $time, what, got, want);
    errors++;
  endtask

  // Send one input word, with a random gap ahead of it
  task automatic send_word(input logic [7:0] b, input logic last);
    sfd_pkg::in_word_t  w;
    sfd_pkg::out_word_t o;
    w.in_byte = b;
    w.in_last = last;
    if (!quiet && $urandom_range(0, 99) < IDLE_PCT) begin
      item_valid <= 1'b0;
      @(posedge clk);
    end
    item_valid <= 1'b1;
    item       <= w;
    do @(posedge clk); while (item_stall);
    if (decode_byte(w, o)) expected_words.push_back(o);
    items_sent++;
  endtask

  // Close any open frame, then hold the sender until every word is back
  task automatic wait_idle();
    if (dec_phase != sfd_pkg::PH_IDLE) send_word(dec_cfg.frame_byte, 1'b1);
    item_valid <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write one register and track it in the predicted copy
  task automatic write_reg(input logic [sfd_pkg::CFG_IDX_BITS-1:0] idx,
                           input logic [sfd_pkg::CFG_DAT_BITS-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      sfd_pkg::CFG_FRAME_BYTE:   dec_cfg.frame_byte   = data[7:0];
      sfd_pkg::CFG_ESCAPE_BYTE:  dec_cfg.escape_byte  = data[7:0];
      sfd_pkg::CFG_FRAME_SUBST:  dec_cfg.frame_subst  = data[7:0];
      sfd_pkg::CFG_ESCAPE_SUBST: dec_cfg.escape_subst = data[7:0];
      sfd_pkg::CFG_CRC_POLY:     dec_cfg.crc_poly     = data;
      sfd_pkg::CFG_CRC_SEED:     dec_cfg.crc_seed     = data;
      sfd_pkg::CFG_CRC_XOROUT:   dec_cfg.crc_xorout   = data;
      sfd_pkg::CFG_CRC_REFLECT:  dec_cfg.crc_reflect  = data[0];
      default: ;
    endcase
  endtask

  // Load a full register set while idle; junk fills the unused upper bits
  task automatic apply_config(input sfd_pkg::cfg_t c);
    logic [15:0]                      junk;
    logic [sfd_pkg::CFG_IDX_BITS-1:0] bad_idx;
    int                               idx_val;
    wait_idle();
    junk = 16'($urandom);
    write_reg(sfd_pkg::CFG_FRAME_BYTE, {junk[7:0], c.frame_byte});
    write_reg(sfd_pkg::CFG_ESCAPE_BYTE, {junk[15:8], c.escape_byte});
    junk = 16'($urandom);
    write_reg(sfd_pkg::CFG_FRAME_SUBST, {junk[7:0], c.frame_subst});
    write_reg(sfd_pkg::CFG_ESCAPE_SUBST, {junk[15:8], c.escape_subst});
    write_reg(sfd_pkg::CFG_CRC_POLY, c.crc_poly);
    write_reg(sfd_pkg::CFG_CRC_SEED, c.crc_seed);
    write_reg(sfd_pkg::CFG_CRC_XOROUT, c.crc_xorout);
    junk = 16'($urandom);
    write_reg(sfd_pkg::CFG_CRC_REFLECT, {junk[15:1], c.crc_reflect});
    // An index past the register file must change nothing
    idx_val = $urandom_range(NUM_REGS, (1 << sfd_pkg::CFG_IDX_BITS) - 1);
    bad_idx = idx_val[sfd_pkg::CFG_IDX_BITS-1:0];
    junk    = 16'($urandom);
    write_reg(bad_idx, junk);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic sfd_pkg::cfg_t random_config();
    sfd_pkg::cfg_t c;
    c.frame_byte = 8'($urandom);
    do c.escape_byte = 8'($urandom); while (c.escape_byte == c.frame_byte);
    c.frame_subst = 8'($urandom);
    do c.escape_subst = 8'($urandom); while (c.escape_subst == c.frame_subst);
    c.crc_poly    = 16'($urandom);
    c.crc_seed    = 16'($urandom);
    c.crc_xorout  = 16'($urandom);
    c.crc_reflect = 1'($urandom);
    return c;
  endfunction

  // Build, stuff and send one packet of the given kind
  task automatic send_frame(input frame_kind_t kind, input int len);
    logic [7:0]  body[$];
    logic [7:0]  b;
    logic [15:0] crc;
    int          i;
    int          cut;
    crc = dec_cfg.crc_seed;
    for (i = 0; i < len; i++) begin
      case ($urandom_range(0, 7))
        0:       b = dec_cfg.frame_byte;
        1:       b = dec_cfg.escape_byte;
        2:       b = 8'h00;
        3:       b = 8'hFF;
        default: b = 8'($urandom);
      endcase
      crc = crc_feed(crc, b);
      body.push_back(b);
    end
    if (kind == FR_SHORT) begin
      while (body.size() > 1) void'(body.pop_back());
    end else begin
      crc = crc_final_value(crc);
      if (kind == FR_BAD_CRC) crc = crc ^ (16'h0001 << $urandom_range(0, 15));
      body.push_back(crc[15:8]);
      body.push_back(crc[7:0]);
    end
    // Opening byte
    if (kind == FR_BAD_START) begin
      do b = 8'($urandom); while (b == dec_cfg.frame_byte);
      send_word(b, 1'b0);
    end else begin
      send_word(dec_cfg.frame_byte, 1'b0);
    end
    // Body; a frame byte is sometimes left raw, which decodes as itself
    cut = (kind == FR_BAD_ESC) ? $urandom_range(0, body.size()) : -1;
    for (i = 0; i <= body.size(); i++) begin
      if (i == cut) begin
        send_word(dec_cfg.escape_byte, 1'b0);
        do b = 8'($urandom); while (b == dec_cfg.frame_subst || b == dec_cfg.escape_subst);
        send_word(b, 1'b0);
      end
      if (i < body.size()) begin
        if (body[i] == dec_cfg.escape_byte) begin
          send_word(dec_cfg.escape_byte, 1'b0);
          send_word(dec_cfg.escape_subst, 1'b0);
        end else if (body[i] == dec_cfg.frame_byte && $urandom_range(0, 2) != 0) begin
          send_word(dec_cfg.escape_byte, 1'b0);
          send_word(dec_cfg.frame_subst, 1'b0);
        end else begin
          send_word(body[i], 1'b0);
        end
      end
    end
    if (kind == FR_ESC_END) send_word(dec_cfg.escape_byte, 1'b0);
    // Closing byte
    if (kind == FR_BAD_END) begin
      do b = 8'($urandom); while (b == dec_cfg.frame_byte);
      send_word(b, 1'b1);
    end else begin
      send_word(dec_cfg.frame_byte, 1'b1);
    end
  endtask

  // Pick one packet or a burst of noise; most picks are well-formed
  task automatic send_random_unit();
    int pick;
    int len;
    pick = $urandom_range(0, 19);
    len  = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 40) : $urandom_range(0, 8);
    if (pick < 11) send_frame(FR_GOOD, len);
    else if (pick == 11) send_frame(FR_BAD_CRC, len);
    else if (pick == 12) send_frame(FR_BAD_ESC, len);
    else if (pick == 13) send_frame(FR_ESC_END, len);
    else if (pick == 14) send_frame(FR_SHORT, len);
    else if (pick == 15) send_frame(FR_BAD_START, len);
    else if (pick == 16) send_frame(FR_BAD_END, len);
    else begin
      repeat ($urandom_range(1, 6)) begin
        if ($urandom_range(0, 3) == 0) send_word(dec_cfg.frame_byte, $urandom_range(0, 7) == 0);
        else send_word(8'($urandom), $urandom_range(0, 7) == 0);
      end
    end
  endtask

  // Hand-picked packets under the reset register values
  task automatic test_directed_cases();
    // One-byte packet
    send_word(dec_cfg.frame_byte, 1'b1);
    // Bad opening byte that is also the last one
    send_word(8'hFF, 1'b1);
    // Bad opening byte, then the rest of the frame is dropped
    send_word(8'h00, 1'b0);
    send_word(dec_cfg.frame_byte, 1'b0);
    send_word(dec_cfg.frame_byte, 1'b1);
    // Bad escape, then the rest is dropped
    send_word(dec_cfg.frame_byte, 1'b0);
    send_word(dec_cfg.escape_byte, 1'b0);
    send_word(8'h00, 1'b0);
    send_word(dec_cfg.frame_byte, 1'b1);
    // Escape still pending at the closing byte
    send_word(dec_cfg.frame_byte, 1'b0);
    send_word(dec_cfg.escape_byte, 1'b0);
    send_word(dec_cfg.frame_byte, 1'b1);
    // Too short
    send_word(dec_cfg.frame_byte, 1'b0);
    send_word(8'h41, 1'b0);
    send_word(dec_cfg.frame_byte, 1'b1);
    // Bad closing byte wins over too short
    send_word(dec_cfg.frame_byte, 1'b0);
    send_word(8'h41, 1'b0);
    send_word(8'hFF, 1'b1);
    send_frame(FR_GOOD, 2);
    send_frame(FR_BAD_CRC, 0);
    wait_idle();
  endtask

  // Extreme, common and random register settings, ten packets or noise bursts each
  task automatic test_register_settings();
    sfd_pkg::cfg_t c;
    int            k;
    for (k = 0; k < 4; k++) begin
      case (k)
        0: begin
          c.frame_byte = 8'h00;  c.escape_byte  = 8'hFF;
          c.frame_subst = 8'hFF; c.escape_subst = 8'h00;
          c.crc_poly = 16'hFFFF; c.crc_seed = 16'hFFFF;
          c.crc_xorout = 16'hFFFF; c.crc_reflect = 1'b0;
        end
        1: begin
          c.frame_byte = 8'hFF;  c.escape_byte  = 8'h00;
          c.frame_subst = 8'h00; c.escape_subst = 8'hFF;
          c.crc_poly = 16'h0000; c.crc_seed = 16'h0000;
          c.crc_xorout = 16'h0000; c.crc_reflect = 1'b1;
        end
        2: begin
          c.frame_byte = sfd_pkg::RST_FRAME_BYTE;
          c.escape_byte  = sfd_pkg::RST_ESCAPE_BYTE;
          c.frame_subst = sfd_pkg::RST_FRAME_SUBST;
          c.escape_subst = sfd_pkg::RST_ESCAPE_SUBST;
          c.crc_poly = 16'h1021; c.crc_seed = 16'hFFFF;
          c.crc_xorout = 16'h0000; c.crc_reflect = 1'b0;
        end
        default: c = random_config();
      endcase
      apply_config(c);
      repeat (10) send_random_unit();
    end
  endtask

  // Long random run; a new register set once PHASE_ITEMS words have gone since the last
  task automatic test_random_traffic();
    int start;
    int phase_start;
    start       = items_sent;
    phase_start = items_sent;
    quiet       = 1'b1;
    apply_config(random_config());
    while (items_sent - start < RANDOM_ITEMS) begin
      if (items_sent - start >= QUIET_ITEMS) quiet = 1'b0;
      if (items_sent - phase_start >= PHASE_ITEMS) begin
        apply_config(random_config());
        phase_start = items_sent;
      end
      send_random_unit();
    end
    quiet = 1'b0;
  endtask

  // Receiver stall
  always @(posedge clk) begin
    if (rst) result_stall <= 1'b0;
    else result_stall <= !quiet && ($urandom_range(0, 99) < IDLE_PCT);
  end

  // Check each accepted result word against the oldest prediction
  always @(posedge clk) begin : check_words
    sfd_pkg::out_word_t want;
    if (!rst && result_valid && !result_stall) begin
      if (expected_words.size() == 0) begin
        report_mismatch("result word with none expected", 16'(result), 16'h0000);
      end else begin
        want = expected_words.pop_front();
        if (result.out_has_byte !== want.out_has_byte)
          report_mismatch("out_has_byte", 16'(result.out_has_byte), 16'(want.out_has_byte));
        if (result.out_byte !== want.out_byte)
          report_mismatch("out_byte", 16'(result.out_byte), 16'(want.out_byte));
        if (result.out_last !== want.out_last)
          report_mismatch("out_last", 16'(result.out_last), 16'(want.out_last));
        if (result.status !== want.status)
          report_mismatch("status", 16'(result.status), 16'(want.status));
      end
    end
  end

  initial begin
    dec_cfg.frame_byte   = sfd_pkg::RST_FRAME_BYTE;
    dec_cfg.escape_byte  = sfd_pkg::RST_ESCAPE_BYTE;
    dec_cfg.frame_subst  = sfd_pkg::RST_FRAME_SUBST;
    dec_cfg.escape_subst = sfd_pkg::RST_ESCAPE_SUBST;
    dec_cfg.crc_poly     = sfd_pkg::RST_CRC_POLY;
    dec_cfg.crc_seed     = sfd_pkg::RST_CRC_SEED;
    dec_cfg.crc_xorout   = sfd_pkg::RST_CRC_XOROUT;
    dec_cfg.crc_reflect  = sfd_pkg::RST_CRC_REFLECT;
    dec_phase            = sfd_pkg::PH_IDLE;
    dec_esc              = 1'b0;
    dec_hold             = '0;
    dec_hold_cnt         = '0;
    dec_crc              = '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    test_directed_cases();
    test_register_settings();
    test_random_traffic();
    wait_idle();
    if (errors == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

  // Watchdog
  initial begin
    #5000000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
